/* design/soa_pkg.sv */
// ----------------------------------------------------------------------------
// soa_pkg
// Shared types and codes of the slab object allocator.
// ----------------------------------------------------------------------------
package soa_pkg;

    localparam int NUM_SLABS_DEFAULT   = 8;
    localparam int MAX_OBJECTS_DEFAULT = 64;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLAB = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;
    localparam logic [1:0] STATUS_BUSY    = 2'd3;

    localparam logic [1:0] LIST_USED = 2'd0;
    localparam logic [1:0] LIST_PART = 2'd1;
    localparam logic [1:0] LIST_FREE = 2'd2;

    localparam logic [2:0] REG_OBJECTS_PER_SLAB = 3'd0;
    localparam logic [2:0] REG_SLAB_LIMIT       = 3'd4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] slab_id;
        logic [5:0] object_index;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] given_slab;
        logic [5:0] given_index;
        logic       slab_created;
    } rsp_t;

endpackage

/* design/soa_ram.sv */
// ----------------------------------------------------------------------------
// soa_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module soa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* design/slab_object_allocator.sv */
// ----------------------------------------------------------------------------
// slab_object_allocator
// Hands out and takes back object slots held in a set of slabs.
// ----------------------------------------------------------------------------
// A request on req (req_valid, req_stall) is allocate, free or release all.
// Each request gives one response on rsp (rsp_valid, rsp_stall).
// An allocate served from an existing slab picks the slab, reads the
// free-list RAM and then writes it back before it responds. Creating a slab
// first writes its free list into the RAM, one slot a cycle, for every slot
// of the slab size (objects_per_slab held to the range 1 to MAX_OBJECTS).
// A free reads the RAM, then writes it back; frees rejected on their slab or
// index, release all and failed allocations answer straight from idle, while
// a free of a slot that is not out is found bad at the write back.
// One request is in flight at a time; the next is taken once the response
// register is empty again, so a stalled response holds off new requests.
// Without stalls a new request can be taken in the cycle after the response
// is taken. Reset empties all lists and marks every slab unused; no RAM
// clearing is needed since a slab's slots are written when it is created.
// The user is to write the registers through the APB port only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module slab_object_allocator #(
    parameter int NUM_SLABS   = soa_pkg::NUM_SLABS_DEFAULT,
    parameter int MAX_OBJECTS = soa_pkg::MAX_OBJECTS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  soa_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output soa_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import soa_pkg::*;

    localparam int SLAB_W = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
    localparam int OBJ_W  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W  = $clog2(MAX_OBJECTS + 1);
    localparam int LIVE_W = $clog2(NUM_SLABS + 1);
    localparam int ADDR_W = SLAB_W + OBJ_W;
    localparam int DEPTH  = NUM_SLABS * (2 ** OBJ_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_POP_RD,
        ST_POP_WB,
        ST_FREE_WB
    } state_t;

    state_t state_reg, state_next;

    logic [6:0] objects_per_slab_reg;
    logic [3:0] slab_limit_reg;

    logic              slab_live_reg   [NUM_SLABS];
    logic              slab_live_next  [NUM_SLABS];
    logic [CNT_W-1:0]  used_count_reg  [NUM_SLABS];
    logic [CNT_W-1:0]  used_count_next [NUM_SLABS];
    logic [OBJ_W-1:0]  free_head_reg   [NUM_SLABS];
    logic [OBJ_W-1:0]  free_head_next  [NUM_SLABS];
    logic [SLAB_W-1:0] link_next_reg   [NUM_SLABS];
    logic [SLAB_W-1:0] link_next_next  [NUM_SLABS];
    logic [SLAB_W-1:0] link_prev_reg   [NUM_SLABS];
    logic [SLAB_W-1:0] link_prev_next  [NUM_SLABS];
    logic [1:0]        which_list_reg  [NUM_SLABS];
    logic [1:0]        which_list_next [NUM_SLABS];
    logic [SLAB_W-1:0] list_head_reg   [3];
    logic [SLAB_W-1:0] list_head_next  [3];
    logic [SLAB_W-1:0] list_tail_reg   [3];
    logic [SLAB_W-1:0] list_tail_next  [3];
    logic              list_ne_reg     [3];
    logic              list_ne_next    [3];
    logic [LIVE_W-1:0] live_cnt_reg, live_cnt_next;

    logic [SLAB_W-1:0] cs_reg, cs_next;
    logic [OBJ_W-1:0]  i_reg, i_next;
    logic [OBJ_W-1:0]  sw_reg, sw_next;
    logic              created_reg, created_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [OBJ_W:0]    ram_wdata;
    logic [OBJ_W:0]    ram_rdata;

    logic [CNT_W-1:0]  cap;
    int                lim_eff;
    logic [SLAB_W-1:0] first_unused;
    logic              found_unused;
    logic              req_accept;
    logic [SLAB_W-1:0] fs;
    logic [OBJ_W-1:0]  fi;
    logic              cfg_write;

    logic              mv_rm, mv_push, mv_front;
    logic [1:0]        mv_list;
    logic [SLAB_W-1:0] mv_slab;
    logic              clear_all;
    logic [1:0]        ml;
    logic [SLAB_W-1:0] mp, mn;
    logic [CNT_W-1:0]  used_inc, used_dec;

    soa_ram #(
        .WIDTH (OBJ_W + 1),
        .DEPTH (DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req_accept = req_valid && !req_stall;
    assign req_stall  = (state_reg != ST_IDLE) || rsp_valid_reg;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign fs         = SLAB_W'(req.slab_id);
    assign fi         = OBJ_W'(req.object_index);

    always_comb
    begin
        if (objects_per_slab_reg == 7'd0)
        begin
            cap = CNT_W'(1);
        end
        else if (32'(objects_per_slab_reg) > MAX_OBJECTS)
        begin
            cap = CNT_W'(MAX_OBJECTS);
        end
        else
        begin
            cap = CNT_W'(objects_per_slab_reg);
        end
        lim_eff = (32'(slab_limit_reg) > NUM_SLABS) ? NUM_SLABS : 32'(slab_limit_reg);
    end

    always_comb
    begin
        first_unused = '0;
        found_unused = 1'b0;
        for (int k = NUM_SLABS - 1; k >= 0; k--)
        begin
            if (!slab_live_reg[k])
            begin
                first_unused = SLAB_W'(k);
                found_unused = 1'b1;
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_OBJECTS_PER_SLAB)
        begin
            prdata = 32'(objects_per_slab_reg);
        end
        else if (paddr == REG_SLAB_LIMIT)
        begin
            prdata = 32'(slab_limit_reg);
        end
    end

    always_comb
    begin
        slab_live_next  = slab_live_reg;
        used_count_next = used_count_reg;
        free_head_next  = free_head_reg;
        link_next_next  = link_next_reg;
        link_prev_next  = link_prev_reg;
        which_list_next = which_list_reg;
        list_head_next  = list_head_reg;
        list_tail_next  = list_tail_reg;
        list_ne_next    = list_ne_reg;
        live_cnt_next   = live_cnt_reg;
        state_next      = state_reg;
        cs_next         = cs_reg;
        i_next          = i_reg;
        sw_next         = sw_reg;
        created_next    = created_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        ram_we          = 1'b0;
        ram_addr        = '0;
        ram_wdata       = '0;
        mv_rm           = 1'b0;
        mv_push         = 1'b0;
        mv_front        = 1'b0;
        mv_list         = LIST_USED;
        mv_slab         = cs_reg;
        clear_all       = 1'b0;
        ml              = LIST_USED;
        mp              = '0;
        mn              = '0;
        used_inc        = used_count_reg[cs_reg] + CNT_W'(1);
        used_dec        = used_count_reg[cs_reg] - CNT_W'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    created_next = 1'b0;
                    rsp_next     = '0;
                    unique case (req.opcode)
                        OP_ALLOC:
                        begin
                            if (list_ne_reg[LIST_PART])
                            begin
                                cs_next    = list_head_reg[LIST_PART];
                                state_next = ST_POP_RD;
                            end
                            else if (list_ne_reg[LIST_FREE])
                            begin
                                cs_next    = list_head_reg[LIST_FREE];
                                mv_slab    = list_head_reg[LIST_FREE];
                                mv_rm      = 1'b1;
                                mv_push    = 1'b1;
                                mv_list    = LIST_PART;
                                state_next = ST_POP_RD;
                            end
                            else if (found_unused && (32'(live_cnt_reg) < lim_eff))
                            begin
                                cs_next                      = first_unused;
                                slab_live_next[first_unused]  = 1'b1;
                                used_count_next[first_unused] = '0;
                                free_head_next[first_unused]  = OBJ_W'(cap - CNT_W'(1));
                                live_cnt_next                = live_cnt_reg + LIVE_W'(1);
                                mv_slab                      = first_unused;
                                mv_push                      = 1'b1;
                                mv_list                      = LIST_PART;
                                sw_next                      = '0;
                                created_next                 = 1'b1;
                                state_next                   = ST_SWEEP;
                            end
                            else
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = STATUS_NO_SLAB;
                            end
                        end
                        OP_FREE:
                        begin
                            if ((32'(req.slab_id) >= NUM_SLABS) || !slab_live_reg[fs] ||
                                (32'(req.object_index) >= 32'(cap)) ||
                                (used_count_reg[fs] == '0))
                            begin
                                rsp_valid_next  = 1'b1;
                                rsp_next.status = STATUS_BAD;
                            end
                            else
                            begin
                                cs_next    = fs;
                                i_next     = fi;
                                ram_addr   = {fs, fi};
                                state_next = ST_FREE_WB;
                            end
                        end
                        OP_RELEASE:
                        begin
                            rsp_valid_next = 1'b1;
                            if (list_ne_reg[LIST_USED] || list_ne_reg[LIST_PART])
                            begin
                                rsp_next.status = STATUS_BUSY;
                            end
                            else
                            begin
                                clear_all = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_addr  = {cs_reg, sw_reg};
                ram_wdata = {1'b0, (sw_reg == '0) ? sw_reg : sw_reg - OBJ_W'(1)};
                if (CNT_W'(sw_reg) == cap - CNT_W'(1))
                begin
                    state_next = ST_POP_RD;
                end
                else
                begin
                    sw_next = sw_reg + OBJ_W'(1);
                end
            end
            ST_POP_RD:
            begin
                ram_addr   = {cs_reg, free_head_reg[cs_reg]};
                i_next     = free_head_reg[cs_reg];
                state_next = ST_POP_WB;
            end
            ST_POP_WB:
            begin
                free_head_next[cs_reg]  = ram_rdata[OBJ_W-1:0];
                ram_we                  = 1'b1;
                ram_addr                = {cs_reg, i_reg};
                ram_wdata               = {1'b1, ram_rdata[OBJ_W-1:0]};
                used_count_next[cs_reg] = used_inc;
                if (used_inc >= cap)
                begin
                    mv_rm   = 1'b1;
                    mv_push = 1'b1;
                    mv_list = LIST_USED;
                end
                rsp_valid_next        = 1'b1;
                rsp_next.status       = STATUS_OK;
                rsp_next.given_slab   = 3'(cs_reg);
                rsp_next.given_index  = 6'(i_reg);
                rsp_next.slab_created = created_reg;
                state_next            = ST_IDLE;
            end
            ST_FREE_WB:
            begin
                rsp_valid_next = 1'b1;
                if (!ram_rdata[OBJ_W])
                begin
                    rsp_next.status = STATUS_BAD;
                end
                else
                begin
                    ram_we                  = 1'b1;
                    ram_addr                = {cs_reg, i_reg};
                    ram_wdata               = {1'b0, free_head_reg[cs_reg]};
                    free_head_next[cs_reg]  = i_reg;
                    used_count_next[cs_reg] = used_dec;
                    if (used_dec == '0)
                    begin
                        mv_rm    = 1'b1;
                        mv_push  = 1'b1;
                        mv_front = 1'b1;
                        mv_list  = LIST_FREE;
                    end
                    else if (used_dec == cap - CNT_W'(1))
                    begin
                        mv_rm    = 1'b1;
                        mv_push  = 1'b1;
                        mv_front = 1'b1;
                        mv_list  = LIST_PART;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_all)
        begin
            for (int k = 0; k < NUM_SLABS; k++)
            begin
                slab_live_next[k]  = 1'b0;
                used_count_next[k] = '0;
                free_head_next[k]  = '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                list_head_next[k] = '0;
                list_tail_next[k] = '0;
                list_ne_next[k]   = 1'b0;
            end
            live_cnt_next = '0;
        end

        if (mv_rm)
        begin
            ml = which_list_next[mv_slab];
            mp = link_prev_next[mv_slab];
            mn = link_next_next[mv_slab];
            if ((list_head_next[ml] == mv_slab) && (list_tail_next[ml] == mv_slab))
            begin
                list_ne_next[ml] = 1'b0;
            end
            else if (list_head_next[ml] == mv_slab)
            begin
                list_head_next[ml] = mn;
            end
            else if (list_tail_next[ml] == mv_slab)
            begin
                list_tail_next[ml] = mp;
            end
            else
            begin
                link_next_next[mp] = mn;
                link_prev_next[mn] = mp;
            end
        end

        if (mv_push)
        begin
            which_list_next[mv_slab] = mv_list;
            if (!list_ne_next[mv_list])
            begin
                list_head_next[mv_list] = mv_slab;
                list_tail_next[mv_list] = mv_slab;
                list_ne_next[mv_list]   = 1'b1;
            end
            else if (mv_front)
            begin
                link_prev_next[list_head_next[mv_list]] = mv_slab;
                link_next_next[mv_slab]                 = list_head_next[mv_list];
                list_head_next[mv_list]                 = mv_slab;
            end
            else
            begin
                link_next_next[list_tail_next[mv_list]] = mv_slab;
                link_prev_next[mv_slab]                 = list_tail_next[mv_list];
                list_tail_next[mv_list]                 = mv_slab;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            objects_per_slab_reg <= 7'd64;
            slab_limit_reg       <= 4'd8;
            live_cnt_reg         <= '0;
            rsp_valid_reg        <= 1'b0;
            for (int k = 0; k < NUM_SLABS; k++)
            begin
                slab_live_reg[k]  <= 1'b0;
                used_count_reg[k] <= '0;
                free_head_reg[k]  <= '0;
                which_list_reg[k] <= LIST_USED;
            end
            for (int k = 0; k < 3; k++)
            begin
                list_head_reg[k] <= '0;
                list_tail_reg[k] <= '0;
                list_ne_reg[k]   <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            live_cnt_reg    <= live_cnt_next;
            rsp_valid_reg   <= rsp_valid_next;
            slab_live_reg   <= slab_live_next;
            used_count_reg  <= used_count_next;
            free_head_reg   <= free_head_next;
            which_list_reg  <= which_list_next;
            list_head_reg   <= list_head_next;
            list_tail_reg   <= list_tail_next;
            list_ne_reg     <= list_ne_next;
            if (cfg_write && (paddr == REG_OBJECTS_PER_SLAB) && (live_cnt_reg == '0))
            begin
                objects_per_slab_reg <= pwdata[6:0];
            end
            if (cfg_write && (paddr == REG_SLAB_LIMIT))
            begin
                slab_limit_reg <= pwdata[3:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        link_next_reg <= link_next_next;
        link_prev_reg <= link_prev_next;
        cs_reg        <= cs_next;
        i_reg         <= i_next;
        sw_reg        <= sw_next;
        created_reg   <= created_next;
        rsp_reg       <= rsp_next;
    end

    logic [NUM_SLABS-1:0] live_vec;

    always_comb
    begin
        for (int k = 0; k < NUM_SLABS; k++)
        begin
            live_vec[k] = slab_live_reg[k];
        end
    end

    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_cnt_reg) == $countones(live_vec))
        else $error("Live slab count disagrees with live flags.");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("Request taken while a request is in flight.");

    a_sweep_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> ram_we)
        else $error("Slab creation does not write its free list.");

    a_pop_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_WB) |=> (rsp_valid_reg && (rsp_reg.status == STATUS_OK)))
        else $error("Allocation finished without an ok response.");

endmodule

/* verif/tb_slab_object_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slab_object_allocator
// Self-checking testbench of the slab object allocator.
// ----------------------------------------------------------------------------
// Requests are driven on the request channel while a behavioral copy of the
// allocator, with its own slab lists and free lists, predicts each response.
// Every response is compared field by field with the oldest prediction.
// The run covers directed corner cases, random traffic that frees objects
// really out and random slots, several register settings, and phases of
// random sender gaps and receiver stalls, including one long receiver hold.
// ----------------------------------------------------------------------------
module tb_slab_object_allocator;
    import soa_pkg::*;

    localparam int SLABS = 8;
    localparam int SLOTS = 64;
    localparam int STALL_LIMIT = 5000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    slab_object_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Allocator state as predicted.
    logic [6:0] slot_count_reg;
    logic [3:0] slab_limit_reg;
    bit         slab_on     [SLABS];
    int         in_use      [SLABS];
    int         top_slot    [SLABS];
    int         next_slot   [SLABS][SLOTS];
    bit         slot_out    [SLABS][SLOTS];
    int         link_next   [SLABS];
    int         link_prev   [SLABS];
    logic [1:0] slab_list   [SLABS];
    int         head_of     [3];
    int         tail_of     [3];
    bit         filled      [3];

    rsp_t       pending_rsps[$];
    int         held_slab[$];
    int         held_slot[$];

    int         mismatches;
    int         rsp_seen;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_cycles;
    int         quiet_cycles;
    int         allocs_ok;
    int         creations;
    int         bad_frees;
    int         busy_releases;
    int         no_slab;

    function automatic void drop_all_slabs();
        for (int s = 0; s < SLABS; s++)
        begin
            slab_on[s] = 0;
            in_use[s] = 0;
            top_slot[s] = 0;
            link_next[s] = 0;
            link_prev[s] = 0;
            slab_list[s] = LIST_USED;
            for (int i = 0; i < SLOTS; i++)
            begin
                next_slot[s][i] = 0;
                slot_out[s][i] = 0;
            end
        end
        for (int l = 0; l < 3; l++)
        begin
            head_of[l] = 0;
            tail_of[l] = 0;
            filled[l] = 0;
        end
        held_slab.delete();
        held_slot.delete();
    endfunction

    function automatic int slots_per_slab();
        if (slot_count_reg == 0)
            return 1;
        if (slot_count_reg > SLOTS)
            return SLOTS;
        return slot_count_reg;
    endfunction

    function automatic void unlink_slab(int s);
        int l;
        l = slab_list[s];
        if (head_of[l] == s && tail_of[l] == s)
            filled[l] = 0;
        else if (head_of[l] == s)
            head_of[l] = link_next[s];
        else if (tail_of[l] == s)
            tail_of[l] = link_prev[s];
        else
        begin
            link_next[link_prev[s]] = link_next[s];
            link_prev[link_next[s]] = link_prev[s];
        end
    endfunction

    function automatic void link_slab(logic [1:0] l, int s, bit at_front);
        slab_list[s] = l;
        if (!filled[l])
        begin
            head_of[l] = s;
            tail_of[l] = s;
            filled[l] = 1;
        end
        else if (at_front)
        begin
            link_prev[head_of[l]] = s;
            link_next[s] = head_of[l];
            head_of[l] = s;
        end
        else
        begin
            link_next[tail_of[l]] = s;
            link_prev[s] = tail_of[l];
            tail_of[l] = s;
        end
    endfunction

    function automatic rsp_t allocator_response(req_t r);
        rsp_t o;
        int   cap;
        int   s;
        int   i;
        int   live;
        int   lim;
        o = '0;
        cap = slots_per_slab();
        if (r.opcode == OP_ALLOC)
        begin
            if (filled[LIST_PART])
                s = head_of[LIST_PART];
            else if (filled[LIST_FREE])
            begin
                s = head_of[LIST_FREE];
                unlink_slab(s);
                link_slab(LIST_PART, s, 0);
            end
            else
            begin
                live = 0;
                for (int k = 0; k < SLABS; k++)
                    live += slab_on[k];
                lim = (slab_limit_reg > SLABS) ? SLABS : slab_limit_reg;
                s = SLABS;
                if (live < lim)
                    for (int k = SLABS - 1; k >= 0; k--)
                        if (!slab_on[k])
                            s = k;
                if (s >= SLABS)
                begin
                    o.status = STATUS_NO_SLAB;
                    no_slab++;
                    return o;
                end
                slab_on[s] = 1;
                in_use[s] = 0;
                for (int k = 0; k < cap; k++)
                begin
                    next_slot[s][k] = (k == 0) ? 0 : k - 1;
                    slot_out[s][k] = 0;
                end
                top_slot[s] = cap - 1;
                link_slab(LIST_PART, s, 0);
                o.slab_created = 1'b1;
                creations++;
            end
            i = top_slot[s];
            top_slot[s] = next_slot[s][i];
            slot_out[s][i] = 1;
            in_use[s]++;
            if (in_use[s] >= cap)
            begin
                unlink_slab(s);
                link_slab(LIST_USED, s, 0);
            end
            o.given_slab = 3'(s);
            o.given_index = 6'(i);
            held_slab.push_back(s);
            held_slot.push_back(i);
            allocs_ok++;
        end
        else if (r.opcode == OP_FREE)
        begin
            s = r.slab_id;
            i = r.object_index;
            if (!slab_on[s] || i >= cap || !slot_out[s][i] || in_use[s] == 0)
            begin
                o.status = STATUS_BAD;
                bad_frees++;
                return o;
            end
            slot_out[s][i] = 0;
            next_slot[s][i] = top_slot[s];
            top_slot[s] = i;
            in_use[s]--;
            if (in_use[s] == 0)
            begin
                unlink_slab(s);
                link_slab(LIST_FREE, s, 1);
            end
            else if (in_use[s] == cap - 1)
            begin
                unlink_slab(s);
                link_slab(LIST_PART, s, 1);
            end
            for (int k = 0; k < held_slab.size(); k++)
                if (held_slab[k] == s && held_slot[k] == i)
                begin
                    held_slab.delete(k);
                    held_slot.delete(k);
                    break;
                end
        end
        else if (r.opcode == OP_RELEASE)
        begin
            if (filled[LIST_USED] || filled[LIST_PART])
            begin
                o.status = STATUS_BUSY;
                busy_releases++;
                return o;
            end
            drop_all_slabs();
        end
        return o;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls plus an optional long hold.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                rsp_stall = 1'b1;
            end
            else
                rsp_stall = ($urandom_range(99) < stall_pct);
        end
    end

    // Response checker.
    initial
    begin
        rsp_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
            begin
                rsp_seen++;
                if (pending_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response %p", rsp);
                end
                else
                begin
                    want = pending_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.given_slab !== want.given_slab ||
                        rsp.given_index !== want.given_index ||
                        rsp.slab_created !== want.slab_created)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d: expected %p, got %p", rsp_seen, want, rsp);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic send_request(logic [1:0] op, int slab, int slot);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req.opcode = op;
        req.slab_id = 3'(slab);
        req.object_index = 6'(slot);
        do
            @(posedge clk);
        while (req_stall);
        pending_rsps.push_back(allocator_response(req));
    endtask

    task automatic go_quiet();
        @(negedge clk);
        req_valid = 1'b0;
        while (pending_rsps.size() > 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == REG_OBJECTS_PER_SLAB)
        begin
            if (!(filled[LIST_USED] || filled[LIST_PART] || filled[LIST_FREE]))
                slot_count_reg = data[6:0];
        end
        else
            slab_limit_reg = data[3:0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic free_random_held();
        int k;
        k = $urandom_range(held_slab.size() - 1);
        send_request(OP_FREE, held_slab[k], held_slot[k]);
    endtask

    task automatic drain_and_release();
        while (held_slab.size() > 0)
            free_random_held();
        send_request(OP_RELEASE, 0, 0);
    endtask

    task automatic set_sizes(int slots, int limit);
        go_quiet();
        write_register(REG_OBJECTS_PER_SLAB, slots);
        write_register(REG_SLAB_LIMIT, limit);
    endtask

    task automatic test_directed();
        send_request(OP_FREE, 0, 0);
        send_request(OP_RELEASE, 0, 0);
        send_request(OP_UNUSED, 7, 63);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_RELEASE, 0, 0);
        send_request(OP_FREE, 0, 62);
        send_request(OP_FREE, 0, 61);
        send_request(OP_FREE, 7, 63);
        send_request(OP_FREE, 0, 63);
        send_request(OP_FREE, 0, 63);
        send_request(OP_FREE, 0, 62);
        send_request(OP_RELEASE, 0, 0);
        set_sizes(2, 2);
        repeat (5) send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 0, 1);
        send_request(OP_ALLOC, 0, 0);
        send_request(OP_FREE, 1, 0);
        send_request(OP_FREE, 1, 1);
        send_request(OP_ALLOC, 0, 0);
        drain_and_release();
    endtask

    task automatic test_random(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 48)
                send_request(OP_ALLOC, 0, 0);
            else if (pick < 88 && held_slab.size() > 0)
                free_random_held();
            else if (pick < 95)
                send_request(OP_FREE, $urandom_range(7), $urandom_range(63));
            else if (pick < 98)
                send_request(OP_RELEASE, $urandom_range(7), $urandom_range(63));
            else
                send_request(OP_UNUSED, $urandom_range(7), $urandom_range(63));
        end
        drain_and_release();
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        repeat (20) send_request(OP_ALLOC, 0, 0);
        drain_and_release();
    endtask

    task automatic test_settings();
        set_sizes(1, 1);
        test_random(60);
        set_sizes(64, 8);
        test_random(150);
        set_sizes(100, 15);
        test_random(60);
        set_sizes(0, 0);
        test_random(20);
        set_sizes(5, 3);
        send_request(OP_ALLOC, 0, 0);
        go_quiet();
        write_register(REG_OBJECTS_PER_SLAB, 9);
        test_random(60);
    endtask

    task automatic test_idle_phases();
        int pcts[4][2] = '{'{0, 0}, '{66, 0}, '{0, 66}, '{37, 37}};
        for (int p = 0; p < 4; p++)
        begin
            set_sizes($urandom_range(1, 12), $urandom_range(1, 8));
            send_idle_pct = pcts[p][0];
            stall_pct = pcts[p][1];
            test_random(250);
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        rsp_seen = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        allocs_ok = 0;
        creations = 0;
        bad_frees = 0;
        busy_releases = 0;
        no_slab = 0;
        slot_count_reg = 7'd64;
        slab_limit_reg = 4'd8;
        drop_all_slabs();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_settings();
        test_idle_phases();

        go_quiet();
        mismatches += pending_rsps.size();
        $display("Checked %0d responses: %0d allocations, %0d new slabs, %0d bad frees,",
                 rsp_seen, allocs_ok, creations, bad_frees);
        $display("%0d busy releases and %0d out-of-slab refusals over several settings.",
                 busy_releases, no_slab);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
design/soa_pkg.sv
design/soa_ram.sv
design/slab_object_allocator.sv
verif/tb_slab_object_allocator.sv
